[rtl/core/i2r_pkg.sv]
// ----------------------------------------------------------------------------
// i2r_pkg
// shared types, constants and numeral tables for the integer to roman encoder
// ----------------------------------------------------------------------------
package i2r_pkg;

  localparam int unsigned NumberW    = 16;
  localparam int unsigned ValueW     = 12;
  localparam int unsigned CharW      = 8;
  localparam int unsigned NumEntries = 13;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned MaxOut     = 15;
  localparam int unsigned CntW       = 4;

  localparam int unsigned MaxValueDef = 3999;
  localparam int unsigned CmdDepthDef = 2;
  localparam int unsigned OutDepthDef = 2;

  // ascii letters
  localparam logic [CharW-1:0] ChNone = 8'h00;
  localparam logic [CharW-1:0] ChM    = 8'h4D;
  localparam logic [CharW-1:0] ChD    = 8'h44;
  localparam logic [CharW-1:0] ChC    = 8'h43;
  localparam logic [CharW-1:0] ChL    = 8'h4C;
  localparam logic [CharW-1:0] ChX    = 8'h58;
  localparam logic [CharW-1:0] ChV    = 8'h56;
  localparam logic [CharW-1:0] ChI    = 8'h49;

  typedef logic [IdxW-1:0]   idx_t;
  typedef logic [ValueW-1:0] value_t;
  typedef logic [CharW-1:0]  char_t;

  // classified number handed from front to back
  typedef struct packed {
    logic   err;
    value_t value;
  } cmd_t;

  // one output beat
  typedef struct packed {
    char_t symbol_char;
    logic  range_error;
    logic  last_symbol;
  } res_t;

  function automatic value_t weight(input idx_t idx);
    value_t w;
    case (idx)
      4'd0:    w = 12'd1000;
      4'd1:    w = 12'd900;
      4'd2:    w = 12'd500;
      4'd3:    w = 12'd400;
      4'd4:    w = 12'd100;
      4'd5:    w = 12'd90;
      4'd6:    w = 12'd50;
      4'd7:    w = 12'd40;
      4'd8:    w = 12'd10;
      4'd9:    w = 12'd9;
      4'd10:   w = 12'd5;
      4'd11:   w = 12'd4;
      4'd12:   w = 12'd1;
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic char_t first_char(input idx_t idx);
    char_t c;
    case (idx)
      4'd0:    c = ChM;
      4'd1:    c = ChC;
      4'd2:    c = ChD;
      4'd3:    c = ChC;
      4'd4:    c = ChC;
      4'd5:    c = ChX;
      4'd6:    c = ChL;
      4'd7:    c = ChX;
      4'd8:    c = ChX;
      4'd9:    c = ChI;
      4'd10:   c = ChV;
      4'd11:   c = ChI;
      4'd12:   c = ChI;
      default: c = ChNone;
    endcase
    return c;
  endfunction

  function automatic char_t second_char(input idx_t idx);
    char_t c;
    case (idx)
      4'd1:    c = ChM;
      4'd3:    c = ChD;
      4'd5:    c = ChC;
      4'd7:    c = ChL;
      4'd9:    c = ChX;
      4'd11:   c = ChV;
      default: c = ChNone;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/i2r_fifo.sv]
// ----------------------------------------------------------------------------
// i2r_fifo
// small register queue with push/full and pop/empty sides
// ----------------------------------------------------------------------------
module i2r_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/core/i2r_front.sv]
// ----------------------------------------------------------------------------
// i2r_front
// range check of an incoming number, builds the command for the back end
// ----------------------------------------------------------------------------
module i2r_front
  import i2r_pkg::*;
#(
  parameter int unsigned MAX_VALUE = MaxValueDef
) (
  input  logic [NumberW-1:0] number_in_i,
  output cmd_t               cmd_o
);

  localparam logic [NumberW-1:0] MaxVal = NumberW'(MAX_VALUE);

  // zero and anything above the top value are errors
  assign cmd_o.err   = (number_in_i == '0) || (number_in_i > MaxVal);
  assign cmd_o.value = number_in_i[ValueW-1:0];

endmodule

[rtl/core/i2r_back.sv]
// ----------------------------------------------------------------------------
// i2r_back
// letter sequencer: greedy walk over the numeral table, while the output queue has room one letter a cycle
// ----------------------------------------------------------------------------
module i2r_back
  import i2r_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  input  cmd_t cmd_i,
  output logic cmd_pop_o,
  output logic res_push_o,
  input  logic res_full_i,
  output res_t res_o
);

  logic            busy_q, busy_d;
  value_t          rem_q, rem_d;
  idx_t            pos_q, pos_d;
  logic            pend_q, pend_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  idx_t            sel;
  value_t          rem_sub;
  logic            has_second;
  logic            cap;

  // largest table entry that still fits
  always_comb begin
    sel = '0;
    for (int i = NumEntries - 1; i >= 0; i--) begin
      if (rem_q >= weight(IdxW'(i))) begin
        sel = IdxW'(i);
      end
    end
  end

  assign rem_sub    = rem_q - weight(sel);
  assign has_second = (second_char(sel) != ChNone);
  assign cap        = (cnt_q == CntW'(MaxOut - 1));

  always_comb begin
    busy_d     = busy_q;
    rem_d      = rem_q;
    pos_d      = pos_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    if (!busy_q) begin
      if (cmd_valid_i) begin
        if (cmd_i.err) begin
          if (!res_full_i) begin
            cmd_pop_o         = 1'b1;
            res_push_o        = 1'b1;
            res_o.symbol_char = ChNone;
            res_o.range_error = 1'b1;
            res_o.last_symbol = 1'b1;
          end
        end else begin
          cmd_pop_o = 1'b1;
          busy_d    = 1'b1;
          rem_d     = cmd_i.value;
          pos_d     = '0;
          pend_d    = 1'b0;
          cnt_d     = '0;
        end
      end
    end else if (!res_full_i) begin
      res_push_o = 1'b1;
      cnt_d      = cnt_q + 1'b1;
      if (pend_q) begin
        // second letter of a subtractive pair
        res_o.symbol_char = second_char(pos_q);
        res_o.last_symbol = (rem_q == '0) || cap;
        pend_d            = 1'b0;
      end else begin
        res_o.symbol_char = first_char(sel);
        res_o.last_symbol = (!has_second && (rem_sub == '0)) || cap;
        rem_d             = rem_sub;
        pos_d             = sel;
        pend_d            = has_second && !cap;
      end
      if (res_o.last_symbol) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
      pos_q  <= '0;
      pend_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
      pos_q  <= pos_d;
      pend_q <= pend_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

[rtl/core/integer_to_roman_encoder.sv]
// ----------------------------------------------------------------------------
// integer_to_roman_encoder
// converts one number per input beat into its roman numeral, one ascii
// letter per output beat
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | push / full        | number_in_i (16 bit)
//  output   | pop / empty        | symbol_char_o, range_error_o, last_symbol_o
//
//  flow: a valid number is loaded into the back end sequencer, which then
//    emits its letters in order; an error number gives a single error beat
//  rate: the sequencer emits one letter a cycle when the output queue has room
//  reset: rst_ni clears both queues and the sequencer at once
//  stalls: the front keeps taking numbers while the command queue has room;
//    the back end holds when the output queue is full
// ----------------------------------------------------------------------------
module integer_to_roman_encoder
  import i2r_pkg::*;
#(
  parameter int unsigned MAX_VALUE = MaxValueDef,
  parameter int unsigned CMD_DEPTH = CmdDepthDef,
  parameter int unsigned OUT_DEPTH = OutDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input queue side
  input  logic               push,
  output logic               full,
  input  logic [NumberW-1:0] number_in_i,
  // result queue side
  output logic               empty,
  input  logic               pop,
  output logic [CharW-1:0]   symbol_char_o,
  output logic               range_error_o,
  output logic               last_symbol_o
);

  cmd_t cmd_in;     // classified number entering the command queue
  cmd_t cmd_out;    // head of the command queue
  logic cmd_empty;
  logic cmd_pop;
  res_t res_in;     // letter beat from the sequencer
  res_t res_out;    // head of the output queue
  logic res_push;
  logic res_full;

  // front: range check
  i2r_front #(
    .MAX_VALUE (MAX_VALUE)
  ) u_front (
    .number_in_i (number_in_i),
    .cmd_o       (cmd_in)
  );

  // queue between front and back
  i2r_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_out)
  );

  // back: letter sequencer
  i2r_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (!cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_full_i  (res_full),
    .res_o       (res_in)
  );

  // output queue, keeps the sequencer going while a beat waits
  i2r_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .full_o  (res_full),
    .wdata_i (res_in),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_out)
  );

  assign symbol_char_o = res_out.symbol_char;
  assign range_error_o = res_out.range_error;
  assign last_symbol_o = res_out.last_symbol;

endmodule

[rtl/core/i2r_chk.sv]
// ----------------------------------------------------------------------------
// i2r_chk
// port level checks for the integer to roman encoder
// ----------------------------------------------------------------------------
module i2r_chk
  import i2r_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               push,
  input logic               full,
  input logic [NumberW-1:0] number_in_i,
  input logic               empty,
  input logic               pop,
  input logic [CharW-1:0]   symbol_char_o,
  input logic               range_error_o,
  input logic               last_symbol_o
);

  // nothing to show while in reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> empty)
    else $error("result shown during reset");

  // an accepted number carries known bits
  a_push_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full) |-> !$isunknown(number_in_i))
    else $error("accepted number has unknown bits");

  // an error beat is a lone, blank, final beat
  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && range_error_o) |-> (last_symbol_o && symbol_char_o == ChNone))
    else $error("malformed error beat");

  // a letter beat carries a numeral letter
  a_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !range_error_o) |->
      (symbol_char_o == ChM || symbol_char_o == ChD || symbol_char_o == ChC ||
       symbol_char_o == ChL || symbol_char_o == ChX || symbol_char_o == ChV ||
       symbol_char_o == ChI))
    else $error("letter beat is not a numeral letter");

  // a waiting beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(symbol_char_o) &&
      $stable(range_error_o) && $stable(last_symbol_o)))
    else $error("waiting beat changed");

endmodule

bind integer_to_roman_encoder i2r_chk u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .push          (push),
  .full          (full),
  .number_in_i   (number_in_i),
  .empty         (empty),
  .pop           (pop),
  .symbol_char_o (symbol_char_o),
  .range_error_o (range_error_o),
  .last_symbol_o (last_symbol_o)
);
